// File: rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared constants, register indexes and types of the setpoint shaper.
// ----------------------------------------------------------------------------
package rcs_pkg;

    // default parameter values
    localparam int TIMEOUT_TICKS_DEF     = 300;
    localparam int TICK_PERIOD_US_DEF    = 5000;
    localparam int ROTATE_ITERATIONS_DEF = 14;

    // angle constants, Q4.12
    localparam int Q_PI       = 12868;
    localparam int Q_HALF_PI  = 6434;
    localparam int Q_TWO_PI   = 25736;
    localparam int DEAD_ZONE  = 205;
    localparam int INV_GAIN   = 19898;
    localparam int THR_OFFSET = 16384;
    // trapezoid halving times microseconds per second
    localparam longint TRAP_DIVISOR = 2000000;

    // serial multiplier operand widths
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW + 1;

    // rotator datapath widths
    localparam int ROT_XW = 34;
    localparam int ROT_ZW = 32;

    // configuration register indexes
    localparam logic [2:0] REG_ROLL_RANGE   = 3'd0;
    localparam logic [2:0] REG_PITCH_RANGE  = 3'd1;
    localparam logic [2:0] REG_YAW_RANGE    = 3'd2;
    localparam logic [2:0] REG_THR_MIN      = 3'd3;
    localparam logic [2:0] REG_THR_MAX      = 3'd4;
    localparam logic [2:0] REG_ROT_EN       = 3'd5;
    localparam logic [2:0] REG_HDG_OFFSET   = 3'd6;
    localparam logic [2:0] REG_DBG_NO_TMO   = 3'd7;

    // atan(2^-i), Q4.28
    localparam logic [31:0] ATAN_Q28 [16] = '{
        32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290,
        32'd16755422,  32'd8385879,   32'd4193963,  32'd2097109,
        32'd1048571,   32'd524287,    32'd262144,   32'd131072,
        32'd65536,     32'd32768,     32'd16384,    32'd8192
    };

    typedef struct packed {
        logic               new_frame;
        logic signed [15:0] throttle_channel;
        logic signed [15:0] roll_channel;
        logic signed [15:0] pitch_channel;
        logic signed [15:0] yaw_channel;
        logic signed [15:0] kill_channel;
        logic signed [15:0] aux_channel;
        logic signed [14:0] heading;
    } t_in_item;

endpackage

// File: rtl/rcs_in_if.sv
// ----------------------------------------------------------------------------
// rcs_in_if
// Input channel: one control tick per transfer.
// ----------------------------------------------------------------------------
interface rcs_in_if;
    logic               valid;
    logic               ready;
    logic               new_frame;
    logic signed [15:0] throttle_channel;
    logic signed [15:0] roll_channel;
    logic signed [15:0] pitch_channel;
    logic signed [15:0] yaw_channel;
    logic signed [15:0] kill_channel;
    logic signed [15:0] aux_channel;
    logic signed [14:0] heading;

    modport source (
        output valid, new_frame, throttle_channel, roll_channel, pitch_channel,
               yaw_channel, kill_channel, aux_channel, heading,
        input  ready
    );
    modport sink (
        input  valid, new_frame, throttle_channel, roll_channel, pitch_channel,
               yaw_channel, kill_channel, aux_channel, heading,
        output ready
    );
endinterface

// File: rtl/rcs_out_if.sv
// ----------------------------------------------------------------------------
// rcs_out_if
// Output channel: one set of setpoints per transfer.
// ----------------------------------------------------------------------------
interface rcs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_ref;
    logic signed [15:0] pitch_ref;
    logic signed [15:0] yaw_rate_cmd;
    logic signed [31:0] yaw_ref;
    logic signed [14:0] kill_value;
    logic signed [15:0] aux_value;
    logic signed [15:0] aux_previous;
    logic        [15:0] throttle_out;
    logic               link_lost;

    modport source (
        output valid, roll_ref, pitch_ref, yaw_rate_cmd, yaw_ref, kill_value,
               aux_value, aux_previous, throttle_out, link_lost,
        input  ready
    );
    modport sink (
        input  valid, roll_ref, pitch_ref, yaw_rate_cmd, yaw_ref, kill_value,
               aux_value, aux_previous, throttle_out, link_lost,
        output ready
    );
endinterface

// File: rtl/rcs_serial_mul.sv
// ----------------------------------------------------------------------------
// rcs_serial_mul
// Shift-add multiplier: signed A times unsigned B, one bit of B per cycle.
// ----------------------------------------------------------------------------
module rcs_serial_mul #(
    parameter int AW = rcs_pkg::MUL_AW,
    parameter int BW = rcs_pkg::MUL_BW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [AW-1:0]   i_a,
    input  logic        [BW-1:0]   i_b,
    output logic                   o_done,
    output logic signed [AW+BW:0]  o_p
);
    localparam int PW = AW + BW + 1;
    localparam int CW = $clog2(BW);

    logic signed [AW-1:0] r_a;
    logic signed [PW-1:0] r_acc, n_acc;
    logic signed [AW:0]   hi;
    logic [CW-1:0]        r_cnt;
    logic                 r_run, r_done;

    // add A into the upper part when the current B bit is set, then shift
    always_comb begin
        hi = $signed(r_acc[PW-1:BW]);
        if (r_acc[0]) begin
            hi = $signed(r_acc[PW-1:BW]) + (AW+1)'(r_a);
        end
        n_acc = $signed({hi, r_acc[BW-1:0]}) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(BW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= $signed({(AW+1)'(0), i_b});
        end else if (r_run) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// File: rtl/rcs_cordic.sv
// ----------------------------------------------------------------------------
// rcs_cordic
// Iterative CORDIC rotator, one micro-rotation per cycle, gain not removed.
// ----------------------------------------------------------------------------
module rcs_cordic #(
    parameter int XW   = rcs_pkg::ROT_XW,
    parameter int ZW   = rcs_pkg::ROT_ZW,
    parameter int ITER = rcs_pkg::ROTATE_ITERATIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_done,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y
);
    localparam int IW = $clog2(ITER);

    logic signed [XW-1:0] r_x, r_y, dx, dy;
    logic signed [ZW-1:0] r_z, at;
    logic [IW-1:0]        r_i;
    logic [3:0]           idx;
    logic                 r_run, r_done;

    always_comb begin
        idx = 4'(r_i);
        dx  = r_y >>> idx;
        dy  = r_x >>> idx;
        at  = ZW'(rcs_pkg::ATAN_Q28[idx]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_i   <= '0;
            end else if (r_run) begin
                r_i <= r_i + 1'b1;
                if (r_i == IW'(ITER - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_run) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

// File: rtl/rcs_serial_div.sv
// ----------------------------------------------------------------------------
// rcs_serial_div
// Restoring division by a constant, one quotient bit per cycle, floor result.
// ----------------------------------------------------------------------------
module rcs_serial_div #(
    parameter int     NW      = 36,
    parameter int     QB      = 8,
    parameter longint DIVISOR = rcs_pkg::TRAP_DIVISOR
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_n,
    output logic                 o_done,
    output logic signed [QB:0]   o_q
);
    localparam int RW = NW + 2;
    localparam int CW = $clog2(QB + 1);

    logic [RW-1:0] r_rem, r_dv, n_ext, mag;
    logic [QB-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_neg, r_run, r_done;

    // negative dividend: floor needs the magnitude rounded up
    always_comb begin
        n_ext = RW'(i_n);
        mag   = i_n[NW-1] ? (RW'(0) - n_ext + RW'(DIVISOR - 1)) : n_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QB - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= mag;
            r_dv  <= RW'(DIVISOR) << (QB - 1);
            r_neg <= i_n[NW-1];
            r_q   <= '0;
        end else if (r_run) begin
            r_dv <= r_dv >> 1;
            if (r_rem >= r_dv) begin
                r_rem <= r_rem - r_dv;
                r_q   <= {r_q[QB-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QB-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

// File: rtl/rc_setpoint_shaper.sv
// ----------------------------------------------------------------------------
// rc_setpoint_shaper
// Receiver sticks to attitude, yaw rate, yaw and throttle setpoints.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    control tick: new_frame, six sticks, heading
//  o_out     out  valid / ready    setpoints, aux history, link_lost
//  i_cfg_*   in   write enable     register index, 16-bit write data
//
//  One tick at a time. A tick without a new frame goes straight to the
//  finish state. A frame tick runs five serial multiplies (17-bit
//  multiplier operand, one bit per cycle) plus the trapezoid division (one
//  quotient bit per cycle, 8 at the default tick period); with rotation
//  enabled add a rotator pass and two more multiplies. Synchronous reset,
//  no clearing pass. The output register holds a result while the next
//  tick is taken and worked on.
// ----------------------------------------------------------------------------
module rc_setpoint_shaper #(
    parameter int TIMEOUT_TICKS     = rcs_pkg::TIMEOUT_TICKS_DEF,
    parameter int TICK_PERIOD_US    = rcs_pkg::TICK_PERIOD_US_DEF,
    parameter int ROTATE_ITERATIONS = rcs_pkg::ROTATE_ITERATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    rcs_in_if.sink      i_in,
    rcs_out_if.source   o_out
);
    localparam int AW = rcs_pkg::MUL_AW;
    localparam int BW = rcs_pkg::MUL_BW;
    localparam int PW = rcs_pkg::MUL_PW;
    localparam int XW = rcs_pkg::ROT_XW;
    localparam int ZW = rcs_pkg::ROT_ZW;
    localparam int NW = 36;
    localparam longint QMAX =
        (64'd65536 * longint'(TICK_PERIOD_US)) / rcs_pkg::TRAP_DIVISOR + 2;
    localparam int QB = $clog2(QMAX + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ROTGO = 3'd3;
    localparam logic [2:0] S_ROT   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [2:0] OP_YAW   = 3'd0;
    localparam logic [2:0] OP_THR   = 3'd1;
    localparam logic [2:0] OP_ROLL  = 3'd2;
    localparam logic [2:0] OP_PITCH = 3'd3;
    localparam logic [2:0] OP_GX    = 3'd4;
    localparam logic [2:0] OP_GY    = 3'd5;
    localparam logic [2:0] OP_INC   = 3'd6;

    // configuration
    logic [14:0]        r_roll_range, r_pitch_range, r_yaw_range;
    logic [15:0]        r_thr_min, r_thr_max;
    logic               r_rot_en, r_dbg;
    logic signed [14:0] r_hdg_off;

    // held state
    logic signed [15:0] r_held_roll, r_held_pitch, r_rate_cur, r_rate_prev;
    logic signed [31:0] r_yaw_int;
    logic signed [14:0] r_held_kill;
    logic signed [15:0] r_held_aux, r_held_aux_prev;
    logic        [15:0] r_held_thr;
    logic        [9:0]  r_silence, n_silence;
    logic               r_lost;
    logic signed [QB:0] r_yaw_inc;

    // sequencer
    logic [2:0]            r_state, r_op;
    rcs_pkg::t_in_item     r_in;
    logic signed [17:0]    r_r, r_p;
    logic                  in_xfer, out_xfer, fin_go;

    // output register
    logic                  r_out_valid;
    logic signed [15:0]    r_o_roll, r_o_pitch, r_o_rate, r_o_aux, r_o_aux_prev;
    logic signed [31:0]    r_o_yaw;
    logic signed [14:0]    r_o_kill;
    logic        [15:0]    r_o_thr;
    logic                  r_o_lost;

    // units
    logic                  mul_start, mul_done, rot_done, div_start, div_done;
    logic signed [AW-1:0]  mul_a;
    logic        [BW-1:0]  mul_b;
    logic signed [PW-1:0]  mul_p, mul_np;
    logic signed [XW-1:0]  rot_x0, rot_y0, rot_x, rot_y;
    logic signed [ZW-1:0]  rot_z0;
    logic signed [QB:0]    div_q;

    // datapath helpers
    logic signed [16:0]    thr_diff, thr_off;
    logic signed [PW-1:0]  rate_w, thr_w, ref_w;
    logic signed [15:0]    rate_sat, ref_sat;
    logic signed [18:0]    thr_sum;
    logic        [15:0]    thr_sat;
    logic signed [16:0]    ang0, ang1, ang2;
    logic                  flip;
    logic signed [17:0]    rx, ry;
    logic signed [32:0]    int_sum;
    logic signed [31:0]    int_sat;

    function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
        if (v > PW'(32767)) begin
            return 16'sd32767;
        end else if (v < -PW'(32768)) begin
            return -16'sd32768;
        end
        return 16'(v);
    endfunction

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_out_valid && o_out.ready;
    assign fin_go   = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
    assign i_in.ready = (r_state == S_IDLE);

    // multiplier operands
    always_comb begin
        thr_diff = $signed({1'b0, r_thr_max}) - $signed({1'b0, r_thr_min});
        thr_off  = 17'(r_in.throttle_channel) + 17'(rcs_pkg::THR_OFFSET);
        mul_a = '0;
        mul_b = '0;
        unique case (r_op)
            OP_YAW: begin
                mul_a = AW'(r_in.yaw_channel);
                mul_b = BW'(r_yaw_range);
            end
            OP_THR: begin
                // keep B unsigned: move the sign of a downward span onto A
                if (thr_diff < 0) begin
                    mul_a = -AW'(thr_off);
                    mul_b = BW'(-thr_diff);
                end else begin
                    mul_a = AW'(thr_off);
                    mul_b = BW'(thr_diff);
                end
            end
            OP_ROLL: begin
                mul_a = AW'(r_in.roll_channel);
                mul_b = BW'(r_roll_range);
            end
            OP_PITCH: begin
                mul_a = AW'(r_in.pitch_channel);
                mul_b = BW'(r_pitch_range);
            end
            OP_GX: begin
                mul_a = AW'(rot_x);
                mul_b = BW'(rcs_pkg::INV_GAIN);
            end
            OP_GY: begin
                mul_a = AW'(rot_y);
                mul_b = BW'(rcs_pkg::INV_GAIN);
            end
            OP_INC: begin
                mul_a = AW'(r_rate_cur) + AW'(r_rate_prev);
                mul_b = BW'(TICK_PERIOD_US);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product post-processing
    always_comb begin
        mul_np   = -mul_p;
        rate_w   = mul_p >>> 14;
        rate_sat = sat16(rate_w);
        if (rate_sat > -16'sd205 && rate_sat < 16'sd205) begin
            rate_sat = '0;
        end
        thr_w   = mul_p >>> 15;
        thr_sum = 19'($signed({1'b0, r_thr_min})) + 19'(thr_w);
        if (thr_sum < 0) begin
            thr_sat = '0;
        end else if (thr_sum > 19'sd65535) begin
            thr_sat = 16'hFFFF;
        end else begin
            thr_sat = thr_sum[15:0];
        end
        ref_w   = mul_p >>> 29;
        ref_sat = sat16(ref_w);
    end

    // rotation angle: wrap into one turn, fold into the right half plane
    always_comb begin
        ang0 = 17'(r_in.heading) - 17'(r_hdg_off);
        ang1 = ang0;
        if (ang0 > 17'(rcs_pkg::Q_PI)) begin
            ang1 = ang0 - 17'(rcs_pkg::Q_TWO_PI);
        end else if (ang0 < -17'(rcs_pkg::Q_PI)) begin
            ang1 = ang0 + 17'(rcs_pkg::Q_TWO_PI);
        end
        flip = 1'b0;
        ang2 = ang1;
        if (ang1 > 17'(rcs_pkg::Q_HALF_PI)) begin
            flip = 1'b1;
            ang2 = ang1 - 17'(rcs_pkg::Q_PI);
        end else if (ang1 < -17'(rcs_pkg::Q_HALF_PI)) begin
            flip = 1'b1;
            ang2 = ang1 + 17'(rcs_pkg::Q_PI);
        end
        rx     = flip ? -r_r : r_r;
        ry     = flip ? -r_p : r_p;
        rot_x0 = XW'(rx) <<< 14;
        rot_y0 = XW'(ry) <<< 14;
        rot_z0 = ZW'(ang2) <<< 16;
    end

    // silence counter and yaw integration
    always_comb begin
        n_silence = (r_silence == 10'h3FF) ? r_silence : r_silence + 1'b1;
        int_sum   = 33'(r_yaw_int) + 33'(r_yaw_inc);
        if (int_sum > 33'sd2147483647) begin
            int_sat = 32'sh7FFFFFFF;
        end else if (int_sum < -33'sd2147483648) begin
            int_sat = 32'sh80000000;
        end else begin
            int_sat = 32'(int_sum);
        end
    end

    assign mul_start = (r_state == S_LOAD);
    assign div_start = (r_state == S_MUL) && mul_done && (r_op == OP_INC);

    rcs_serial_mul #(.AW(AW), .BW(BW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    rcs_cordic #(.XW(XW), .ZW(ZW), .ITER(ROTATE_ITERATIONS)) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ROTGO),
        .i_x     (rot_x0),
        .i_y     (rot_y0),
        .i_z     (rot_z0),
        .o_done  (rot_done),
        .o_x     (rot_x),
        .o_y     (rot_y)
    );

    rcs_serial_div #(.NW(NW), .QB(QB), .DIVISOR(rcs_pkg::TRAP_DIVISOR)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (NW'(mul_p)),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_range  <= 15'd2048;
            r_pitch_range <= 15'd2048;
            r_yaw_range   <= 15'd6144;
            r_thr_min     <= 16'd0;
            r_thr_max     <= 16'd29491;
            r_rot_en      <= 1'b0;
            r_hdg_off     <= '0;
            r_dbg         <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcs_pkg::REG_ROLL_RANGE:  r_roll_range  <= i_cfg_data[14:0];
                rcs_pkg::REG_PITCH_RANGE: r_pitch_range <= i_cfg_data[14:0];
                rcs_pkg::REG_YAW_RANGE:   r_yaw_range   <= i_cfg_data[14:0];
                rcs_pkg::REG_THR_MIN:     r_thr_min     <= i_cfg_data;
                rcs_pkg::REG_THR_MAX:     r_thr_max     <= i_cfg_data;
                rcs_pkg::REG_ROT_EN:      r_rot_en      <= i_cfg_data[0];
                rcs_pkg::REG_HDG_OFFSET:  r_hdg_off     <= $signed(i_cfg_data[14:0]);
                rcs_pkg::REG_DBG_NO_TMO:  r_dbg         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_op            <= OP_YAW;
            r_held_roll     <= '0;
            r_held_pitch    <= '0;
            r_rate_cur      <= '0;
            r_rate_prev     <= '0;
            r_yaw_int       <= '0;
            r_held_kill     <= '0;
            r_held_aux      <= '0;
            r_held_aux_prev <= '0;
            r_held_thr      <= '0;
            r_silence       <= '0;
            r_lost          <= 1'b0;
            r_yaw_inc       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.new_frame) begin
                            r_silence       <= '0;
                            r_held_kill     <= i_in.kill_channel[15:1];
                            r_held_aux_prev <= r_held_aux;
                            r_held_aux      <= i_in.aux_channel;
                            r_op            <= OP_YAW;
                            r_state         <= S_LOAD;
                        end else begin
                            if (!r_dbg) begin
                                r_silence <= n_silence;
                                if (32'(n_silence) > TIMEOUT_TICKS) begin
                                    r_lost <= 1'b1;
                                end
                            end
                            r_state <= S_FIN;
                        end
                    end
                end
                S_LOAD: r_state <= S_MUL;
                S_MUL: begin
                    if (mul_done) begin
                        unique case (r_op)
                            OP_YAW: begin
                                r_rate_prev <= r_rate_cur;
                                r_rate_cur  <= rate_sat;
                                r_op        <= OP_THR;
                                r_state     <= S_LOAD;
                            end
                            OP_THR: begin
                                r_held_thr <= thr_sat;
                                r_op       <= OP_ROLL;
                                r_state    <= S_LOAD;
                            end
                            OP_ROLL: begin
                                r_r     <= 18'(mul_np >>> 14);
                                r_op    <= OP_PITCH;
                                r_state <= S_LOAD;
                            end
                            OP_PITCH: begin
                                r_p <= 18'(mul_np >>> 14);
                                if (r_rot_en) begin
                                    r_state <= S_ROTGO;
                                end else begin
                                    r_held_roll  <= sat16(PW'(r_r));
                                    r_held_pitch <= sat16(mul_np >>> 14);
                                    r_op         <= OP_INC;
                                    r_state      <= S_LOAD;
                                end
                            end
                            OP_GX: begin
                                r_held_roll <= ref_sat;
                                r_op        <= OP_GY;
                                r_state     <= S_LOAD;
                            end
                            OP_GY: begin
                                r_held_pitch <= ref_sat;
                                r_op         <= OP_INC;
                                r_state      <= S_LOAD;
                            end
                            OP_INC: r_state <= S_DIV;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ROTGO: r_state <= S_ROT;
                S_ROT: begin
                    if (rot_done) begin
                        r_op    <= OP_GX;
                        r_state <= S_LOAD;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_yaw_inc <= div_q;
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_yaw_int <= int_sat;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.new_frame        <= i_in.new_frame;
            r_in.throttle_channel <= i_in.throttle_channel;
            r_in.roll_channel     <= i_in.roll_channel;
            r_in.pitch_channel    <= i_in.pitch_channel;
            r_in.yaw_channel      <= i_in.yaw_channel;
            r_in.kill_channel     <= i_in.kill_channel;
            r_in.aux_channel      <= i_in.aux_channel;
            r_in.heading          <= i_in.heading;
        end
        if (fin_go) begin
            r_o_roll     <= r_held_roll;
            r_o_pitch    <= r_held_pitch;
            r_o_rate     <= r_rate_cur;
            r_o_yaw      <= int_sat;
            r_o_kill     <= r_held_kill;
            r_o_aux      <= r_held_aux;
            r_o_aux_prev <= r_held_aux_prev;
            r_o_thr      <= r_held_thr;
            r_o_lost     <= r_lost;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.roll_ref     = r_o_roll;
    assign o_out.pitch_ref    = r_o_pitch;
    assign o_out.yaw_rate_cmd = r_o_rate;
    assign o_out.yaw_ref      = r_o_yaw;
    assign o_out.kill_value   = r_o_kill;
    assign o_out.aux_value    = r_o_aux;
    assign o_out.aux_previous = r_o_aux_prev;
    assign o_out.throttle_out = r_o_thr;
    assign o_out.link_lost    = r_o_lost;

    a_lost_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lost |=> r_lost)
        else $error("link lost flag cleared without reset");

    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiplier finished outside its wait state");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_rot_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rot_done |-> (r_state == S_ROT))
        else $error("rotator finished outside its wait state");

endmodule

// File: test/rc_setpoint_shaper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_setpoint_shaper_tb
// Drives control ticks under several register settings and idling patterns,
// predicts every setpoint set in the testbench and checks each transfer.
// ----------------------------------------------------------------------------
module rc_setpoint_shaper_tb;
    import rcs_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int TAIL_CYCLES = 400;

    typedef struct packed {
        logic signed [15:0] roll_ref;
        logic signed [15:0] pitch_ref;
        logic signed [15:0] yaw_rate_cmd;
        logic signed [31:0] yaw_ref;
        logic signed [14:0] kill_value;
        logic signed [15:0] aux_value;
        logic signed [15:0] aux_previous;
        logic        [15:0] throttle_out;
        logic               link_lost;
    } t_setpoints;

    // Setpoint predictor plus the store of pending setpoint sets.
    class setpoint_board;
        logic [15:0]   regs [8];
        longint        roll_q, pitch_q, rate_now, rate_prev, yaw_acc;
        longint        kill_q, aux_q, aux_prev_q, thr_q;
        int            silence;
        bit            lost;
        t_setpoints    pending [$];
        int            errors;

        function new();
            regs[REG_ROLL_RANGE] = 2048;
            regs[REG_PITCH_RANGE] = 2048;
            regs[REG_YAW_RANGE] = 6144;
            regs[REG_THR_MIN] = 0;
            regs[REG_THR_MAX] = 29491;
            regs[REG_ROT_EN] = 0;
            regs[REG_HDG_OFFSET] = 0;
            regs[REG_DBG_NO_TMO] = 0;
            roll_q = 0; pitch_q = 0; rate_now = 0; rate_prev = 0; yaw_acc = 0;
            kill_q = 0; aux_q = 0; aux_prev_q = 0; thr_q = 0;
            silence = 0; lost = 0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_ROLL_RANGE, REG_PITCH_RANGE, REG_YAW_RANGE,
                REG_HDG_OFFSET: regs[idx] = data & 16'h7fff;
                REG_ROT_EN, REG_DBG_NO_TMO: regs[idx] = data & 16'h0001;
                default: regs[idx] = data;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint div_floor(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0) q -= 1;
            return q;
        endfunction

        // CORDIC rotation of (r, p) by angle a, Q4.12
        function void rotate(inout longint r, inout longint p, input longint a);
            longint x, y, z, dx, dy;
            x = r * 16384;
            y = p * 16384;
            while (a > Q_PI) a -= Q_TWO_PI;
            while (a < -Q_PI) a += Q_TWO_PI;
            if (a > Q_HALF_PI) begin
                x = -x; y = -y; a -= Q_PI;
            end else if (a < -Q_HALF_PI) begin
                x = -x; y = -y; a += Q_PI;
            end
            z = a * 65536;
            for (int i = 0; i < ROTATE_ITERATIONS_DEF && i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(ATAN_Q28[i]);
                end else begin
                    x += dx; y -= dy; z += longint'(ATAN_Q28[i]);
                end
            end
            r = (x * INV_GAIN) >>> 29;
            p = (y * INV_GAIN) >>> 29;
        endfunction

        function void note_tick(t_in_item it);
            longint r, p, rate, t, ofs;
            t_setpoints s;
            if (it.new_frame) begin
                r = (-(longint'(it.roll_channel) * longint'(regs[REG_ROLL_RANGE]))) >>> 14;
                p = (-(longint'(it.pitch_channel) * longint'(regs[REG_PITCH_RANGE]))) >>> 14;
                if (regs[REG_ROT_EN][0]) begin
                    ofs = longint'($signed(regs[REG_HDG_OFFSET][14:0]));
                    rotate(r, p, longint'(it.heading) - ofs);
                end
                roll_q = clamp(r, -32768, 32767);
                pitch_q = clamp(p, -32768, 32767);
                rate = clamp((longint'(it.yaw_channel) * longint'(regs[REG_YAW_RANGE])) >>> 14,
                             -32768, 32767);
                if (rate > -DEAD_ZONE && rate < DEAD_ZONE) rate = 0;
                rate_prev = rate_now;
                rate_now = rate;
                kill_q = longint'(it.kill_channel) >>> 1;
                aux_prev_q = aux_q;
                aux_q = longint'(it.aux_channel);
                t = longint'(regs[REG_THR_MIN]) +
                    (((longint'(it.throttle_channel) + THR_OFFSET) *
                      (longint'(regs[REG_THR_MAX]) - longint'(regs[REG_THR_MIN]))) >>> 15);
                thr_q = clamp(t, 0, 65535);
                silence = 0;
            end else if (!regs[REG_DBG_NO_TMO][0]) begin
                if (silence < 1023) silence++;
                if (silence > TIMEOUT_TICKS_DEF) lost = 1;
            end
            yaw_acc = clamp(yaw_acc + div_floor((rate_now + rate_prev) * TICK_PERIOD_US_DEF,
                                                TRAP_DIVISOR),
                            -64'sd2147483648, 64'sd2147483647);
            s.roll_ref = roll_q[15:0];
            s.pitch_ref = pitch_q[15:0];
            s.yaw_rate_cmd = rate_now[15:0];
            s.yaw_ref = yaw_acc[31:0];
            s.kill_value = kill_q[14:0];
            s.aux_value = aux_q[15:0];
            s.aux_previous = aux_prev_q[15:0];
            s.throttle_out = thr_q[15:0];
            s.link_lost = lost;
            pending.push_back(s);
        endfunction

        function void check_setpoints(t_setpoints got);
            t_setpoints e;
            if (pending.size() == 0) begin
                $error("setpoint transfer with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.roll_ref !== e.roll_ref) begin
                $error("roll_ref expected %0d got %0d", e.roll_ref, got.roll_ref); errors++;
            end
            if (got.pitch_ref !== e.pitch_ref) begin
                $error("pitch_ref expected %0d got %0d", e.pitch_ref, got.pitch_ref); errors++;
            end
            if (got.yaw_rate_cmd !== e.yaw_rate_cmd) begin
                $error("yaw_rate_cmd expected %0d got %0d", e.yaw_rate_cmd, got.yaw_rate_cmd);
                errors++;
            end
            if (got.yaw_ref !== e.yaw_ref) begin
                $error("yaw_ref expected %0d got %0d", e.yaw_ref, got.yaw_ref); errors++;
            end
            if (got.kill_value !== e.kill_value) begin
                $error("kill_value expected %0d got %0d", e.kill_value, got.kill_value);
                errors++;
            end
            if (got.aux_value !== e.aux_value) begin
                $error("aux_value expected %0d got %0d", e.aux_value, got.aux_value); errors++;
            end
            if (got.aux_previous !== e.aux_previous) begin
                $error("aux_previous expected %0d got %0d", e.aux_previous, got.aux_previous);
                errors++;
            end
            if (got.throttle_out !== e.throttle_out) begin
                $error("throttle_out expected %0d got %0d", e.throttle_out, got.throttle_out);
                errors++;
            end
            if (got.link_lost !== e.link_lost) begin
                $error("link_lost expected %0d got %0d", e.link_lost, got.link_lost); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = REG_ROLL_RANGE;
    logic [15:0] i_cfg_data = '0;

    rcs_in_if  tick_if ();
    rcs_out_if sp_if ();

    rc_setpoint_shaper u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_if.sink),
        .o_out      (sp_if.source)
    );

    setpoint_board board = new();
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int            hold_off = 0;
    int            cycle_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        sp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                sp_if.ready = 1'b0;
            end else begin
                sp_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sp_if.valid && sp_if.ready)
            board.check_setpoints({sp_if.roll_ref, sp_if.pitch_ref, sp_if.yaw_rate_cmd,
                                   sp_if.yaw_ref, sp_if.kill_value, sp_if.aux_value,
                                   sp_if.aux_previous, sp_if.throttle_out, sp_if.link_lost});
    end

    // entered and left at a falling edge; valid stays up between back-to-back ticks
    task automatic send_tick(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_if.valid = 1'b0;
            @(negedge i_clk);
        end
        tick_if.valid = 1'b1;
        tick_if.new_frame = it.new_frame;
        tick_if.throttle_channel = it.throttle_channel;
        tick_if.roll_channel = it.roll_channel;
        tick_if.pitch_channel = it.pitch_channel;
        tick_if.yaw_channel = it.yaw_channel;
        tick_if.kill_channel = it.kill_channel;
        tick_if.aux_channel = it.aux_channel;
        tick_if.heading = it.heading;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        board.note_tick(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        tick_if.valid = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        // a silent tick can still be in flight after the last transfer
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(int rr, int pr, int yr, int tmin, int tmax,
                             int rot, int ofs, int dbg);
        write_reg(REG_ROLL_RANGE, 16'(rr));
        write_reg(REG_PITCH_RANGE, 16'(pr));
        write_reg(REG_YAW_RANGE, 16'(yr));
        write_reg(REG_THR_MIN, 16'(tmin));
        write_reg(REG_THR_MAX, 16'(tmax));
        write_reg(REG_ROT_EN, 16'(rot));
        write_reg(REG_HDG_OFFSET, 16'(ofs));
        write_reg(REG_DBG_NO_TMO, 16'(dbg));
    endtask

    function automatic logic signed [15:0] rand_stick();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic t_in_item rand_tick(int frame_pct);
        t_in_item it;
        it.new_frame = ($urandom_range(99) < frame_pct);
        it.throttle_channel = rand_stick();
        it.roll_channel = rand_stick();
        it.pitch_channel = rand_stick();
        it.yaw_channel = rand_stick();
        it.kill_channel = rand_stick();
        it.aux_channel = rand_stick();
        it.heading = 15'($signed($urandom_range(25736)) - 12868);
        return it;
    endfunction

    function automatic t_in_item mk_tick(bit nf, int v, int yaw, int hdg);
        t_in_item it;
        it.new_frame = nf;
        it.throttle_channel = 16'(v);
        it.roll_channel = 16'(v);
        it.pitch_channel = 16'(-v);
        it.yaw_channel = 16'(yaw);
        it.kill_channel = 16'(v);
        it.aux_channel = 16'(-v);
        it.heading = 15'(hdg);
        return it;
    endfunction

    task automatic run_phase(int n, int frame_pct, int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
        repeat (n) send_tick(rand_tick(frame_pct));
        drain();
    endtask

    initial begin
        tick_if.valid = 1'b0;
        tick_if.new_frame = 1'b0;
        tick_if.throttle_channel = '0;
        tick_if.roll_channel = '0;
        tick_if.pitch_channel = '0;
        tick_if.yaw_channel = '0;
        tick_if.kill_channel = '0;
        tick_if.aux_channel = '0;
        tick_if.heading = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: no frame yet, stick extremes, dead zone edges, out of range
        send_tick(mk_tick(0, 0, 0, 0));
        send_tick(mk_tick(1, 16384, 16384, 12868));
        send_tick(mk_tick(1, -16384, -16384, -12868));
        send_tick(mk_tick(1, 0, 544, 0));
        send_tick(mk_tick(1, 0, 547, 0));
        send_tick(mk_tick(1, 0, -547, 0));
        send_tick(mk_tick(1, 32767, 32767, 16383));
        send_tick(mk_tick(1, -32768, -32768, -16384));
        send_tick(mk_tick(0, 1, 1, 1));
        drain();
        write_all(16384, 16384, 16384, 32768, 0, 1, 12868, 0);
        send_tick(mk_tick(1, 16384, 16384, -12868));
        send_tick(mk_tick(1, -16384, -16384, 12868));
        send_tick(mk_tick(1, 32767, -32768, 6434));
        send_tick(mk_tick(1, -32768, 32767, -6435));
        send_tick(mk_tick(1, 8000, 16384, 0));
        drain();
        write_all(0, 0, 0, 65535, 65535, 1, -12868, 1);
        send_tick(mk_tick(1, 16384, 16384, 12868));
        send_tick(mk_tick(0, 0, 0, 0));
        send_tick(mk_tick(1, -16384, -16384, 100));
        drain();

        // long receiver hold-off while ticks keep coming
        write_all(2048, 2048, 6144, 0, 29491, 1, 3000, 0);
        hold_off = 3000;
        run_phase(350, 90, 0);
        run_phase(300, 85, 1);
        write_all(16384, 100, 16384, 32768, 1000, 0, -12868, 1);
        run_phase(300, 70, 2);
        write_all(32767, 32767, 32767, 0, 32768, 1, -5000, 0);
        run_phase(300, 85, 3);
        write_all(777, 16384, 9000, 20000, 40000, 1, 12868, 0);
        run_phase(300, 85, 0);
        write_all(2048, 2048, 6144, 0, 29491, 0, 0, 1);
        run_phase(150, 20, 3);
        // silence with the counter live: link loss latches
        write_all(4000, 4000, 16384, 100, 30000, 1, 0, 0);
        send_idle_pct = 0;
        recv_stall_pct = 14;
        repeat (310) send_tick(mk_tick(0, 0, 0, 0));
        drain();
        run_phase(200, 80, 3);

        tick_if.valid = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
